### rtl/line_rasterizer_stepper_top_macros.svh
// ----------------------------------------------------------------------------
// line rasterizer stepper assertion macros
// concurrent assertion shorthands clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_STEPPER_TOP_MACROS_SVH
`define LINE_RASTERIZER_STEPPER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// shared widths, request codes and helpers for the line rasterizer stepper
// ----------------------------------------------------------------------------
package lrs_pkg;

  // coordinate and derived widths
  localparam int COORD_W = 16;
  localparam int DELTA_W = COORD_W + 1;
  localparam int ERR_W   = COORD_W + 3;
  localparam int FRAME_W = 13;
  localparam int PIX_W   = 12;
  localparam int COLOR_W = 8;
  localparam int CMP_W   = (COORD_W > FRAME_W) ? COORD_W : FRAME_W;

  // frame size after reset
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(640);
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(480);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [FRAME_W-1:0]        frame_t;

  // request codes
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_t;

  // configuration register indexes
  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // true when a point falls outside the frame
  function automatic logic outside(coord_t x, coord_t y, frame_t w, frame_t h);
    logic ox;
    logic oy;
    ox = x[COORD_W-1] | (CMP_W'($unsigned(x)) >= CMP_W'(w));
    oy = y[COORD_W-1] | (CMP_W'($unsigned(y)) >= CMP_W'(h));
    return ox | oy;
  endfunction

endpackage

### rtl/line_rasterizer_stepper_top.sv
// ----------------------------------------------------------------------------
// line_rasterizer_stepper_top
// bresenham line stepper with an exact integer error term
// ----------------------------------------------------------------------------
// A start transaction loads two endpoints and a color and gives a result with
// no pixel; each following step gives at most one pixel of the line and
// marks the last one (or an edge stop, rejection or idle step) with line_done.
// The line state and the result register are both updated at the accepting
// edge, so a new transaction can be taken in every cycle unless the output
// stalls, and the result appears on the output in the cycle after acceptance.
// The input side stalls only while a result waits and out_ready is low.
// Frame size registers are written through the cfg channel, which is always
// ready.
// ----------------------------------------------------------------------------
module line_rasterizer_stepper_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [lrs_pkg::FRAME_W-1:0]  cfg_wdata,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic signed [lrs_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [lrs_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [lrs_pkg::COORD_W-1:0] in_stop_x,
  input  logic signed [lrs_pkg::COORD_W-1:0] in_stop_y,
  input  logic [lrs_pkg::COLOR_W-1:0]  in_red,
  input  logic [lrs_pkg::COLOR_W-1:0]  in_green,
  input  logic [lrs_pkg::COLOR_W-1:0]  in_blue,
  input  logic [lrs_pkg::COLOR_W-1:0]  in_alpha,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lrs_pkg::PIX_W-1:0]    out_pixel_x,
  output logic [lrs_pkg::PIX_W-1:0]    out_pixel_y,
  output logic [lrs_pkg::COLOR_W-1:0]  out_red,
  output logic [lrs_pkg::COLOR_W-1:0]  out_green,
  output logic [lrs_pkg::COLOR_W-1:0]  out_blue,
  output logic [lrs_pkg::COLOR_W-1:0]  out_alpha,
  output logic                         out_pixel_valid,
  output logic                         out_line_done
);
  import lrs_pkg::*;

  // frame size registers
  frame_t frame_width_r;
  frame_t frame_height_r;

  // line state
  logic                     busy_r, busy_nxt;
  logic                     steep_r, steep_nxt;
  coord_t                   step_x_r, step_x_nxt;
  coord_t                   end_x_r, end_x_nxt;
  coord_t                   step_y_r, step_y_nxt;
  logic                     y_dir_r, y_dir_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic [DELTA_W-1:0]       dx_r, dx_nxt;
  logic [DELTA_W-1:0]       dy_r, dy_nxt;
  logic [4*COLOR_W-1:0]     color_r, color_nxt;

  // result register
  logic                     out_valid_r;
  logic [PIX_W-1:0]         pixel_x_r, pixel_x_nxt;
  logic [PIX_W-1:0]         pixel_y_r, pixel_y_nxt;
  logic                     pixel_valid_r, pixel_valid_nxt;
  logic                     line_done_r, line_done_nxt;

  logic                     in_fire;

  // start path
  logic signed [DELTA_W-1:0] ddx, ddy;
  logic [DELTA_W-1:0]        adx, ady;
  logic                      steep_new, swap_new, reject;
  coord_t                    a0, b0, a1, b1, sx, sy, ex, ey;

  // step path
  coord_t                    cur_x, cur_y;
  logic                      cur_out, last_px;
  logic signed [ERR_W:0]     err_sum, err_fix;
  logic                      y_move;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;

  // frame size configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_idx_t'(cfg_index) == CFG_FRAME_WIDTH) begin
        frame_width_r <= cfg_wdata;
      end else begin
        frame_height_r <= cfg_wdata;
      end
    end
  end

  // start setup: steepness, direction and deltas
  always_comb begin
    ddx       = DELTA_W'(in_stop_x) - DELTA_W'(in_start_x);
    ddy       = DELTA_W'(in_stop_y) - DELTA_W'(in_start_y);
    adx       = ddx[DELTA_W-1] ? DELTA_W'(-ddx) : DELTA_W'(ddx);
    ady       = ddy[DELTA_W-1] ? DELTA_W'(-ddy) : DELTA_W'(ddy);
    steep_new = ady > adx;
    a0        = steep_new ? in_start_y : in_start_x;
    b0        = steep_new ? in_start_x : in_start_y;
    a1        = steep_new ? in_stop_y  : in_stop_x;
    b1        = steep_new ? in_stop_x  : in_stop_y;
    swap_new  = a0 > a1;
    sx        = swap_new ? a1 : a0;
    sy        = swap_new ? b1 : b0;
    ex        = swap_new ? a0 : a1;
    ey        = swap_new ? b0 : b1;
    reject    = outside(in_start_x, in_start_y, frame_width_r, frame_height_r) &
                outside(in_stop_x, in_stop_y, frame_width_r, frame_height_r);
  end

  // step: current pixel, bounds and error update
  always_comb begin
    cur_x   = steep_r ? step_y_r : step_x_r;
    cur_y   = steep_r ? step_x_r : step_y_r;
    cur_out = outside(cur_x, cur_y, frame_width_r, frame_height_r);
    last_px = step_x_r >= end_x_r;
    err_sum = {err_r[ERR_W-1], err_r} + $signed({2'b00, dy_r, 1'b0});
    y_move  = err_sum >= $signed({3'b000, dx_r});
    err_fix = err_sum - $signed({2'b00, dx_r, 1'b0});
  end

  // next line state and result
  always_comb begin
    busy_nxt        = busy_r;
    steep_nxt       = steep_r;
    step_x_nxt      = step_x_r;
    end_x_nxt       = end_x_r;
    step_y_nxt      = step_y_r;
    y_dir_nxt       = y_dir_r;
    err_nxt         = err_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    color_nxt       = color_r;
    pixel_x_nxt     = '0;
    pixel_y_nxt     = '0;
    pixel_valid_nxt = 1'b0;
    line_done_nxt   = 1'b0;
    if (req_t'(in_req_type) == REQ_START) begin
      color_nxt = {in_alpha, in_blue, in_green, in_red};
      if (reject) begin
        busy_nxt      = 1'b0;
        line_done_nxt = 1'b1;
      end else begin
        busy_nxt   = 1'b1;
        steep_nxt  = steep_new;
        step_x_nxt = sx;
        end_x_nxt  = ex;
        step_y_nxt = sy;
        y_dir_nxt  = ~(sy < ey);
        err_nxt    = '0;
        dx_nxt     = steep_new ? ady : adx;
        dy_nxt     = steep_new ? adx : ady;
      end
    end else if (!busy_r) begin
      line_done_nxt = 1'b1;
    end else if (cur_out) begin
      busy_nxt      = 1'b0;
      line_done_nxt = 1'b1;
    end else begin
      pixel_x_nxt     = cur_x[PIX_W-1:0];
      pixel_y_nxt     = cur_y[PIX_W-1:0];
      pixel_valid_nxt = 1'b1;
      if (last_px) begin
        busy_nxt      = 1'b0;
        line_done_nxt = 1'b1;
      end else begin
        step_x_nxt = step_x_r + COORD_W'(1);
        if (y_move) begin
          step_y_nxt = step_y_r + {{(COORD_W-1){y_dir_r}}, 1'b1};
          err_nxt    = err_fix[ERR_W-1:0];
        end else begin
          err_nxt    = err_sum[ERR_W-1:0];
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      steep_r  <= 1'b0;
      step_x_r <= '0;
      end_x_r  <= '0;
      step_y_r <= '0;
      y_dir_r  <= 1'b0;
      err_r    <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      color_r  <= '0;
    end else if (in_fire) begin
      busy_r   <= busy_nxt;
      steep_r  <= steep_nxt;
      step_x_r <= step_x_nxt;
      end_x_r  <= end_x_nxt;
      step_y_r <= step_y_nxt;
      y_dir_r  <= y_dir_nxt;
      err_r    <= err_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      color_r  <= color_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pixel_x_r     <= pixel_x_nxt;
      pixel_y_r     <= pixel_y_nxt;
      pixel_valid_r <= pixel_valid_nxt;
      line_done_r   <= line_done_nxt;
    end
  end

  // outputs; the stored color always belongs to the held result
  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pixel_x_r;
  assign out_pixel_y     = pixel_y_r;
  assign out_pixel_valid = pixel_valid_r;
  assign out_line_done   = line_done_r;
  assign out_red         = color_r[COLOR_W-1:0];
  assign out_green       = color_r[2*COLOR_W-1:COLOR_W];
  assign out_blue        = color_r[3*COLOR_W-1:2*COLOR_W];
  assign out_alpha       = color_r[4*COLOR_W-1:3*COLOR_W];

endmodule

### rtl/lrs_checker.sv
// ----------------------------------------------------------------------------
// lrs_checker
// port level checks for the line rasterizer stepper
// ----------------------------------------------------------------------------
`include "line_rasterizer_stepper_top_macros.svh"

module lrs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_req_type,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lrs_pkg::PIX_W-1:0]    out_pixel_x,
  input logic [lrs_pkg::PIX_W-1:0]    out_pixel_y,
  input logic                         out_pixel_valid,
  input logic                         out_line_done
);
  import lrs_pkg::*;

  // every accepted transaction shows its result in the next cycle
  `LRS_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "missing result")

  // an empty result register never stalls the input
  `LRS_ASSERT_SAME(a_no_idle_stall, !out_valid, in_ready, "input stalled while empty")

  // a start transaction never carries a pixel
  `LRS_ASSERT_NEXT(a_start_no_pixel,
    in_valid && in_ready && (req_t'(in_req_type) == REQ_START),
    !out_pixel_valid, "pixel on start result")

  // a result without a pixel reports coordinates of zero
  `LRS_ASSERT_SAME(a_no_pixel_zero, out_valid && !out_pixel_valid,
    (out_pixel_x == '0) && (out_pixel_y == '0), "stray coordinates")

  // a waiting result holds
  `LRS_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
    out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) &&
    $stable(out_pixel_valid) && $stable(out_line_done), "result changed while stalled")

endmodule

bind line_rasterizer_stepper_top lrs_checker u_lrs_checker (.*);

### sim/line_rasterizer_stepper_top_tb.sv
// ----------------------------------------------------------------------------
// line_rasterizer_stepper_top_tb
// self-checking bench for the bresenham line stepper: a short table of
// directed transactions, then random line sequences across several frame
// sizes, every result checked against a typed row or an in-bench line tracer
// ----------------------------------------------------------------------------
module line_rasterizer_stepper_top_tb;
  import lrs_pkg::*;

  localparam int  DIR_ROWS     = 23;
  localparam int  RAND_PHASES  = 10;
  localparam int  PHASE_ITEMS  = 125;
  localparam int  MAX_STEPS    = 40;
  localparam int  LONG_HOLD    = 300;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  RUN_LIMIT    = 100_000_000;
  localparam bit  CHECK_TRACED = 1'b0;
  localparam bit  CHECK_TYPED  = 1'b1;

  // one result transaction
  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    logic               pixel_valid;
    logic               line_done;
  } lrs_result_t;

  // one row of the directed table
  typedef struct packed {
    req_t        req;
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    logic [31:0] rgba;
    logic        typed;
    lrs_result_t want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [FRAME_W-1:0]  cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_req_type;
  coord_t              in_start_x;
  coord_t              in_start_y;
  coord_t              in_stop_x;
  coord_t              in_stop_y;
  logic [COLOR_W-1:0]  in_red;
  logic [COLOR_W-1:0]  in_green;
  logic [COLOR_W-1:0]  in_blue;
  logic [COLOR_W-1:0]  in_alpha;
  logic                out_valid;
  logic                out_ready;
  logic [PIX_W-1:0]    out_pixel_x;
  logic [PIX_W-1:0]    out_pixel_y;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;
  logic [COLOR_W-1:0]  out_alpha;
  logic                out_pixel_valid;
  logic                out_line_done;

  // typed expectation travelling with the offered transaction
  logic                row_typed;
  lrs_result_t         row_want;

  // tracer copy of the frame and line state
  frame_t              frame_w = FRAME_WIDTH_RST;
  frame_t              frame_h = FRAME_HEIGHT_RST;
  logic                ln_active;
  logic                ln_steep;
  coord_t              cur_x;
  coord_t              last_x;
  coord_t              cur_y;
  logic                y_down;
  logic signed [ERR_W-1:0] err_term;
  logic [DELTA_W-1:0]  run_len;
  logic [DELTA_W-1:0]  rise_len;
  logic [31:0]         ink;

  lrs_result_t         pix_q[$];
  int                  mismatches = 0;
  bit                  hold_go = 1'b0;
  bit                  hold_done = 1'b0;

  line_rasterizer_stepper_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_stop_x       (in_stop_x),
    .in_stop_y       (in_stop_y),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_pixel_valid (out_pixel_valid),
    .out_line_done   (out_line_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #RUN_LIMIT;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit off_frame(int x, int y);
    return (x < 0) || (y < 0) || (x >= int'(frame_w)) || (y >= int'(frame_h));
  endfunction

  // line tracer: advances the state by one transaction and gives its result
  function automatic lrs_result_t trace_pixel(req_t req, coord_t ax, coord_t ay,
                                              coord_t bx, coord_t by, logic [31:0] rgba);
    lrs_result_t res;
    int          x0, y0, x1, y1, t;
    coord_t      px, py;
    res = '0;
    if (req == REQ_START) begin
      x0 = ax;
      y0 = ay;
      x1 = bx;
      y1 = by;
      ink = rgba;
      if (off_frame(x0, y0) && off_frame(x1, y1)) begin
        ln_active = 1'b0;
        res.line_done = 1'b1;
      end else begin
        // make the line shallow, then left to right
        ln_steep = mag(y1 - y0) > mag(x1 - x0);
        if (ln_steep) begin
          t = x0; x0 = y0; y0 = t;
          t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
          t = x0; x0 = x1; x1 = t;
          t = y0; y0 = y1; y1 = t;
        end
        run_len  = DELTA_W'(x1 - x0);
        rise_len = DELTA_W'(mag(y1 - y0));
        y_down   = !(y0 < y1);
        cur_x    = coord_t'(x0);
        last_x   = coord_t'(x1);
        cur_y    = coord_t'(y0);
        err_term = '0;
        ln_active = 1'b1;
      end
    end else if (!ln_active) begin
      res.line_done = 1'b1;
    end else begin
      px = ln_steep ? cur_y : cur_x;
      py = ln_steep ? cur_x : cur_y;
      if (off_frame(px, py)) begin
        // edge stop
        ln_active = 1'b0;
        res.line_done = 1'b1;
      end else begin
        res.pixel_x = px[PIX_W-1:0];
        res.pixel_y = py[PIX_W-1:0];
        res.pixel_valid = 1'b1;
        if (cur_x >= last_x) begin
          ln_active = 1'b0;
          res.line_done = 1'b1;
        end else begin
          // exact error term: add 2*dy, compare with dx, correct by 2*dx
          err_term = err_term + $signed(ERR_W'({rise_len, 1'b0}));
          if (err_term >= $signed({1'b0, run_len})) begin
            cur_y = y_down ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
            err_term = err_term - $signed(ERR_W'({run_len, 1'b0}));
          end
          cur_x = cur_x + coord_t'(1);
        end
      end
    end
    res.red   = ink[7:0];
    res.green = ink[15:8];
    res.blue  = ink[23:16];
    res.alpha = ink[31:24];
    return res;
  endfunction

  task automatic match_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // monitor: check results, follow config writes, trace accepted transactions
  always @(posedge clk) begin : monitor
    lrs_result_t got;
    lrs_result_t want;
    lrs_result_t traced;
    if (!rst_n) begin
      frame_w   = FRAME_WIDTH_RST;
      frame_h   = FRAME_HEIGHT_RST;
      ln_active = 1'b0;
      ln_steep  = 1'b0;
      cur_x     = '0;
      last_x    = '0;
      cur_y     = '0;
      y_down    = 1'b0;
      err_term  = '0;
      run_len   = '0;
      rise_len  = '0;
      ink       = '0;
      pix_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.pixel_x     = out_pixel_x;
        got.pixel_y     = out_pixel_y;
        got.red         = out_red;
        got.green       = out_green;
        got.blue        = out_blue;
        got.alpha       = out_alpha;
        got.pixel_valid = out_pixel_valid;
        got.line_done   = out_line_done;
        if (pix_q.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = pix_q.pop_front();
          match_field("pixel_x", want.pixel_x, got.pixel_x);
          match_field("pixel_y", want.pixel_y, got.pixel_y);
          match_field("red", want.red, got.red);
          match_field("green", want.green, got.green);
          match_field("blue", want.blue, got.blue);
          match_field("alpha", want.alpha, got.alpha);
          match_field("pixel_valid", want.pixel_valid, got.pixel_valid);
          match_field("line_done", want.line_done, got.line_done);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) frame_w = cfg_wdata;
        else frame_h = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        traced = trace_pixel(req_t'(in_req_type), in_start_x, in_start_y, in_stop_x,
                             in_stop_y, {in_alpha, in_blue, in_green, in_red});
        pix_q.push_back(row_typed ? row_want : traced);
      end
    end
  end

  // receiver: random back-pressure, one long hold once the random part starts
  initial begin : receiver
    int r;
    int len;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_ready <= 1'b0;
          len = $urandom_range(100, 400);
        end else if (r < 15) begin
          out_ready <= 1'b1;
          len = $urandom_range(20, 80);
        end else if (r < 55) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 6);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic stim_row_t mk_row(req_t req, int sx, int sy, int ex, int ey,
                                       logic [31:0] rgba, bit typed, int wx, int wy,
                                       logic [31:0] wrgba, bit wv, bit wd);
    stim_row_t row;
    row.req   = req;
    row.sx    = coord_t'(sx);
    row.sy    = coord_t'(sy);
    row.ex    = coord_t'(ex);
    row.ey    = coord_t'(ey);
    row.rgba  = rgba;
    row.typed = typed;
    row.want.pixel_x     = PIX_W'(wx);
    row.want.pixel_y     = PIX_W'(wy);
    row.want.red         = wrgba[7:0];
    row.want.green       = wrgba[15:8];
    row.want.blue        = wrgba[23:16];
    row.want.alpha       = wrgba[31:24];
    row.want.pixel_valid = wv;
    row.want.line_done   = wd;
    return row;
  endfunction

  // offer one input transaction and hold it until accepted
  task automatic offer(req_t req, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                       logic [31:0] rgba, logic typed, lrs_result_t want);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_start_x  <= sx;
    in_start_y  <= sy;
    in_stop_x   <= ex;
    in_stop_y   <= ey;
    in_red      <= rgba[7:0];
    in_green    <= rgba[15:8];
    in_blue     <= rgba[23:16];
    in_alpha    <= rgba[31:24];
    row_typed   <= typed;
    row_want    <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender gap after a transaction
  task automatic pause(bit burst);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (burst || r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every expected result is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(frame_t w, frame_t h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t near_frame(frame_t lim);
    return coord_t'(int'($urandom_range(0, int'(lim) + 8)) - 4);
  endfunction

  // one random line: a start followed by a run of steps
  task automatic send_line(bit burst, inout int count);
    coord_t ax, ay, bx, by;
    int     mode, len, nsteps, k;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      // short line near or inside the frame
      ax = near_frame(frame_w);
      ay = near_frame(frame_h);
      bx = coord_t'(int'(ax) + int'($urandom_range(0, 48)) - 24);
      by = coord_t'(int'(ay) + int'($urandom_range(0, 48)) - 24);
    end else if (mode < 85) begin
      ax = near_frame(frame_w);
      ay = near_frame(frame_h);
      bx = near_frame(frame_w);
      by = near_frame(frame_h);
    end else begin
      ax = coord_t'($urandom);
      ay = coord_t'($urandom);
      bx = coord_t'($urandom);
      by = coord_t'($urandom);
    end
    len = mag(int'(bx) - int'(ax));
    if (mag(int'(by) - int'(ay)) > len) len = mag(int'(by) - int'(ay));
    len = len + 1;
    if ($urandom_range(0, 9) < 8) begin
      nsteps = len + $urandom_range(0, 2);
      if (nsteps > MAX_STEPS) nsteps = MAX_STEPS;
    end else begin
      // line abandoned early by the next start
      nsteps = $urandom_range(0, 4);
    end
    offer(REQ_START, ax, ay, bx, by, $urandom, CHECK_TRACED, '0);
    pause(burst);
    for (k = 0; k < nsteps; k++) begin
      offer(REQ_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
            coord_t'($urandom), $urandom, CHECK_TRACED, '0);
      pause(burst);
    end
    count += 1 + nsteps;
  endtask

  // main sequence
  initial begin : driver
    stim_row_t dir_rows [DIR_ROWS];
    frame_t    ws [RAND_PHASES];
    frame_t    hs [RAND_PHASES];
    int        i, p, n;
    bit        burst;
    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_FRAME_WIDTH;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_START;
    in_start_x  <= '0;
    in_start_y  <= '0;
    in_stop_x   <= '0;
    in_stop_y   <= '0;
    in_red      <= '0;
    in_green    <= '0;
    in_blue     <= '0;
    in_alpha    <= '0;
    row_typed   <= 1'b0;
    row_want    <= '0;

    // directed table, run at the reset frame size of 640 by 480
    dir_rows = '{
      // step while idle right after reset
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TYPED, 0, 0, 32'h0, 0, 1),
      // both endpoints outside: rejected, color still loaded
      mk_row(REQ_START, -1, -1, 640, 480, 32'h00ff00ff, CHECK_TYPED,
             0, 0, 32'h00ff00ff, 0, 1),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TYPED, 0, 0, 32'h00ff00ff, 0, 1),
      // shallow line, left open
      mk_row(REQ_START, 0, 0, 5, 2, 32'h78563412, CHECK_TYPED, 0, 0, 32'h78563412, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      // steep, right-to-left line started while busy
      mk_row(REQ_START, 10, 20, 7, 3, 32'h80808080, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      // single point at the far frame corner, then idle
      mk_row(REQ_START, 639, 479, 639, 479, 32'hffffffff, CHECK_TYPED,
             0, 0, 32'hffffffff, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TYPED, 639, 479, 32'hffffffff, 1, 1),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TYPED, 0, 0, 32'hffffffff, 0, 1),
      // line running off the right edge
      mk_row(REQ_START, 637, 5, 645, 5, 32'hff00ff00, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0),
      // coordinate extremes
      mk_row(REQ_START, -32768, -32768, 32767, 32767, 32'h01020304, CHECK_TYPED,
             0, 0, 32'h01020304, 0, 1),
      mk_row(REQ_START, 0, 0, 32767, -32768, 32'h01020304, CHECK_TRACED,
             0, 0, 32'h0, 0, 0),
      mk_row(REQ_STEP, 0, 0, 0, 0, 32'h0, CHECK_TRACED, 0, 0, 32'h0, 0, 0)
    };

    // frame sizes per random phase, including zero and the widest register value
    ws = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd640, 13'd32, 13'd4096, 13'd1,
           frame_t'($urandom_range(1, 4096)), frame_t'($urandom_range(1, 4096))};
    hs = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd480, 13'd24, 13'd1, 13'd4096,
           frame_t'($urandom_range(1, 4096)), frame_t'($urandom_range(1, 4096))};

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      offer(dir_rows[i].req, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
            dir_rows[i].ey, dir_rows[i].rgba, dir_rows[i].typed, dir_rows[i].want);
      pause(1'b0);
    end

    // random phases, frame size changed while idle
    for (p = 0; p < RAND_PHASES; p++) begin
      drain();
      set_frame(ws[p], hs[p]);
      hold_go = 1'b1;
      burst = (p % 3 == 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        // occasional stray step between lines
        if ($urandom_range(0, 19) == 0) begin
          offer(REQ_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), $urandom, CHECK_TRACED, '0);
          pause(burst);
          n++;
        end
        send_line(burst, n);
      end
    end

    drain();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
